FILE: rtl/mfp_pkg.sv
`default_nettype none

package mfp_pkg;

   // rows read for one tile group
   localparam int ROWS_PER_GROUP = 12;

   // request opcodes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_EMIT  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_DATA  = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] pixel_x;
      logic [8:0] pixel_y;
      logic       pixel_on;
   } mfp_req_type;

   typedef struct packed {
      logic [7:0] panel_byte;
      logic [1:0] status;
      logic       last_of_run;
      logic       end_of_frame;
   } mfp_rsp_type;

   typedef enum logic [3:0] {
      S_INIT_CLR,
      S_IDLE,
      S_DECODE,
      S_CLR,
      S_PIX_RD,
      S_PIX_WR,
      S_ACK,
      S_EMIT_RD,
      S_EMIT_WAIT,
      S_EMIT_OUT
   } mfp_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic load_base;
      logic sweep_step;
      logic pix_read;
      logic pix_write;
      logic emit_read;
      logic push_ack;
      logic push_data;
   } mfp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       pix_bad;
      logic       sweep_last;
      logic       row_last;
      logic       out_last;
      logic       out_free;
   } mfp_stat_type;

endpackage

`default_nettype wire

FILE: rtl/mfp_ram.sv
`default_nettype none

module mfp_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 8448,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic [AW-1:0]    addr,
   input  wire logic             we,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/mfp_ctrl.sv
`default_nettype none

module mfp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mfp_pkg::mfp_stat_type stat,
   output mfp_pkg::mfp_cmd_type      cmd
);

   mfp_pkg::mfp_state_type state_ff;
   mfp_pkg::mfp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfp_pkg::S_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfp_pkg::S_INIT_CLR: begin
            if (stat.sweep_last) state_in = mfp_pkg::S_IDLE;
         end
         mfp_pkg::S_IDLE: begin
            if (req_valid) state_in = mfp_pkg::S_DECODE;
         end
         mfp_pkg::S_DECODE: begin
            unique case (stat.opcode)
               mfp_pkg::OP_WRITE: begin
                  state_in = stat.pix_bad ? mfp_pkg::S_ACK : mfp_pkg::S_PIX_RD;
               end
               mfp_pkg::OP_CLEAR: state_in = mfp_pkg::S_CLR;
               mfp_pkg::OP_EMIT:  state_in = mfp_pkg::S_EMIT_RD;
               default:           state_in = mfp_pkg::S_ACK;
            endcase
         end
         mfp_pkg::S_CLR: begin
            if (stat.sweep_last) state_in = mfp_pkg::S_ACK;
         end
         mfp_pkg::S_PIX_RD:    state_in = mfp_pkg::S_PIX_WR;
         mfp_pkg::S_PIX_WR:    state_in = mfp_pkg::S_ACK;
         mfp_pkg::S_ACK: begin
            if (stat.out_free) state_in = mfp_pkg::S_IDLE;
         end
         mfp_pkg::S_EMIT_RD: begin
            if (stat.row_last) state_in = mfp_pkg::S_EMIT_WAIT;
         end
         mfp_pkg::S_EMIT_WAIT: state_in = mfp_pkg::S_EMIT_OUT;
         mfp_pkg::S_EMIT_OUT: begin
            if (stat.out_free && stat.out_last) state_in = mfp_pkg::S_IDLE;
         end
         default: state_in = mfp_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mfp_pkg::S_INIT_CLR:  cmd.sweep_step = 1'b1;
         mfp_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
         end
         mfp_pkg::S_DECODE:    cmd.load_base  = 1'b1;
         mfp_pkg::S_CLR:       cmd.sweep_step = 1'b1;
         mfp_pkg::S_PIX_RD:    cmd.pix_read   = 1'b1;
         mfp_pkg::S_PIX_WR:    cmd.pix_write  = 1'b1;
         mfp_pkg::S_ACK:       cmd.push_ack   = stat.out_free;
         mfp_pkg::S_EMIT_RD:   cmd.emit_read  = 1'b1;
         mfp_pkg::S_EMIT_WAIT: cmd            = '0;
         mfp_pkg::S_EMIT_OUT:  cmd.push_data  = stat.out_free;
         default:              cmd            = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/mfp_datapath.sv
`default_nettype none

module mfp_datapath #(
   parameter  int MAX_WIDTH_BYTES = 32,
   parameter  int MAX_ROW_GROUPS  = 22,
   localparam int WB_W   = $clog2(MAX_WIDTH_BYTES + 1),
   localparam int RG_W   = $clog2(MAX_ROW_GROUPS + 1),
   localparam int DEPTH  = MAX_WIDTH_BYTES * MAX_ROW_GROUPS * mfp_pkg::ROWS_PER_GROUP,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mfp_pkg::mfp_cmd_type  cmd,
   output mfp_pkg::mfp_stat_type      stat,
   input  wire mfp_pkg::mfp_req_type  req_word,
   input  wire logic [WB_W-1:0]       eff_width,
   input  wire logic [RG_W-1:0]       eff_groups,
   output logic      [ADDR_W-1:0]     mem_addr,
   output logic                       mem_we,
   output logic      [7:0]            mem_wdata,
   input  wire logic [7:0]            mem_rdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output mfp_pkg::mfp_rsp_type       rsp_word
);

   localparam int COL_W = (MAX_WIDTH_BYTES > 1) ? $clog2(MAX_WIDTH_BYTES) : 1;
   localparam int GRP_W = (MAX_ROW_GROUPS > 1) ? $clog2(MAX_ROW_GROUPS) : 1;
   localparam int ROW_W = $clog2(MAX_ROW_GROUPS * mfp_pkg::ROWS_PER_GROUP);
   localparam int PROD_W = ROW_W + WB_W;

   mfp_pkg::mfp_req_type req_ff;
   mfp_pkg::mfp_rsp_type rsp_word_ff;
   mfp_pkg::mfp_rsp_type rsp_word_in;
   logic                 rsp_valid_ff;

   logic [ADDR_W-1:0] sweep_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [3:0]        idx_ff;
   logic [1:0]        t_ff;
   logic [1:0]        p_ff;
   logic              cap_ff;
   logic [7:0]        rows_ff [mfp_pkg::ROWS_PER_GROUP];
   logic [COL_W-1:0]  col_ff;
   logic [GRP_W-1:0]  grp_ff;

   logic [COL_W-1:0]  col_eff;
   logic [GRP_W-1:0]  grp_eff;
   logic [WB_W-1:0]   col_next;
   logic [RG_W-1:0]   grp_next;
   logic              col_wrap;
   logic              grp_wrap;
   logic [ROW_W-1:0]  row_sel;
   logic [ADDR_W-1:0] col_sel;
   logic [PROD_W-1:0] prod;
   logic [ADDR_W-1:0] base;
   logic              is_emit;
   logic              pix_bad;
   logic [7:0]        mask;
   logic [7:0]        pix_byte;
   logic [2:0]        sh;
   logic [7:0]        data_byte;
   logic              out_last;
   logic              out_free;
   logic              push;

   // cursor, clamped against the current frame size
   assign col_eff  = (WB_W'(col_ff) < eff_width) ? col_ff : '0;
   assign grp_eff  = (RG_W'(grp_ff) < eff_groups) ? grp_ff : '0;
   assign col_next = WB_W'(col_eff) + WB_W'(1);
   assign grp_next = RG_W'(grp_eff) + RG_W'(1);
   assign col_wrap = (col_next >= eff_width);
   assign grp_wrap = (grp_next >= eff_groups);

   assign is_emit = (req_ff.opcode == mfp_pkg::OP_EMIT);
   assign pix_bad = (32'(req_ff.pixel_x) >= 32'(eff_width) * 8)
                 || (32'(req_ff.pixel_y) >= 32'(eff_groups) * mfp_pkg::ROWS_PER_GROUP);

   // start address: row * width + byte column, one multiplier shared by both uses
   assign row_sel = is_emit ? (ROW_W'({grp_eff, 3'b000}) + ROW_W'({grp_eff, 2'b00}))
                            : ROW_W'(req_ff.pixel_y);
   assign col_sel = is_emit ? ADDR_W'(col_eff) : ADDR_W'(req_ff.pixel_x[7:3]);
   assign prod    = PROD_W'(row_sel) * PROD_W'(eff_width);
   assign base    = ADDR_W'(prod) + col_sel;

   assign mask     = 8'h80 >> req_ff.pixel_x[2:0];
   assign pix_byte = req_ff.pixel_on ? (mem_rdata | mask) : (mem_rdata & ~mask);

   assign mem_addr  = cmd.sweep_step ? sweep_ff : addr_ff;
   assign mem_we    = cmd.sweep_step | cmd.pix_write;
   assign mem_wdata = cmd.sweep_step ? 8'h00 : pix_byte;

   // reorder: 2-bit slice of four rows per byte
   always_comb begin
      sh        = {~p_ff, 1'b0};
      data_byte = '0;
      for (int j = 0; j < 4; j++) begin
         data_byte[7-2*j -: 2] = 2'(rows_ff[{t_ff, 2'b00} + 4'(j)] >> sh);
      end
   end

   assign out_last = (p_ff == 2'd3) && (t_ff == 2'd2);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push     = cmd.push_ack || cmd.push_data;

   always_comb begin
      if (cmd.push_data) begin
         rsp_word_in.panel_byte   = data_byte;
         rsp_word_in.status       = mfp_pkg::STAT_DATA;
         rsp_word_in.last_of_run  = out_last;
         rsp_word_in.end_of_frame = out_last && col_wrap && grp_wrap;
      end else begin
         rsp_word_in.panel_byte   = 8'h00;
         rsp_word_in.status       = ((req_ff.opcode == mfp_pkg::OP_WRITE) && pix_bad)
                                    ? mfp_pkg::STAT_RANGE : mfp_pkg::STAT_DONE;
         rsp_word_in.last_of_run  = 1'b1;
         rsp_word_in.end_of_frame = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_ff <= req_word;
      end
      if (cmd.load_base) begin
         addr_ff <= base;
      end else if (cmd.emit_read) begin
         addr_ff <= addr_ff + ADDR_W'(eff_width);
      end
      if (cap_ff) begin
         for (int i = 0; i < mfp_pkg::ROWS_PER_GROUP - 1; i++) begin
            rows_ff[i] <= rows_ff[i+1];
         end
         rows_ff[mfp_pkg::ROWS_PER_GROUP-1] <= mem_rdata;
      end
      if (push) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         idx_ff       <= '0;
         t_ff         <= '0;
         p_ff         <= '0;
         cap_ff       <= 1'b0;
         col_ff       <= '0;
         grp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff <= cmd.emit_read;
         if (cmd.sweep_step) begin
            sweep_ff <= (sweep_ff == ADDR_W'(DEPTH - 1)) ? '0 : sweep_ff + ADDR_W'(1);
         end
         if (cmd.load_base) begin
            idx_ff <= '0;
            t_ff   <= '0;
            p_ff   <= '0;
         end else begin
            if (cmd.emit_read) begin
               idx_ff <= idx_ff + 4'd1;
            end
            if (cmd.push_data) begin
               if (t_ff == 2'd2) begin
                  t_ff <= '0;
                  p_ff <= p_ff + 2'd1;
               end else begin
                  t_ff <= t_ff + 2'd1;
               end
            end
         end
         if (cmd.push_data && out_last) begin
            if (col_wrap) begin
               col_ff <= '0;
               grp_ff <= grp_wrap ? '0 : GRP_W'(grp_next);
            end else begin
               col_ff <= COL_W'(col_next);
               grp_ff <= grp_eff;
            end
         end
         rsp_valid_ff <= push || (rsp_valid_ff && !rsp_ready);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign stat.opcode     = req_ff.opcode;
   assign stat.pix_bad    = pix_bad;
   assign stat.sweep_last = (sweep_ff == ADDR_W'(DEPTH - 1));
   assign stat.row_last   = (idx_ff == 4'(mfp_pkg::ROWS_PER_GROUP - 1));
   assign stat.out_last   = out_last;
   assign stat.out_free   = out_free;

endmodule

`default_nettype wire

FILE: rtl/mono_framebuffer_panel_reorder.sv
// write pixel: decode, frame read, modified write, then the acknowledgement word
// emit: 12 frame reads (one memory port, one row a cycle) then 12 words, one a cycle
//   while the output is free; every item is finished before the next one is taken
// clear: one memory entry a cycle, all MAX_WIDTH_BYTES*MAX_ROW_GROUPS*12 entries (8448)
// reset: synchronous, active high; afterwards the same clearing sweep runs before
//   req_ready rises, csr writes are taken at any time
`default_nettype none

module mono_framebuffer_panel_reorder #(
   parameter int MAX_WIDTH_BYTES = 32,
   parameter int MAX_ROW_GROUPS  = 22
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mfp_pkg::mfp_req_type req_word,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mfp_pkg::mfp_rsp_type      rsp_word,
   // register port
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic      [31:0]          csr_prdata,
   output logic                      csr_pready
);

   localparam int WB_W   = $clog2(MAX_WIDTH_BYTES + 1);
   localparam int RG_W   = $clog2(MAX_ROW_GROUPS + 1);
   localparam int DEPTH  = MAX_WIDTH_BYTES * MAX_ROW_GROUPS * mfp_pkg::ROWS_PER_GROUP;
   localparam int ADDR_W = $clog2(DEPTH);

   // register index, taken from address bit 2
   localparam logic REG_WIDTH_BYTES = 1'b0;
   localparam logic REG_ROW_GROUPS  = 1'b1;

   logic [5:0]        width_bytes_ff;
   logic [4:0]        row_groups_ff;
   logic              csr_write;
   logic [WB_W-1:0]   eff_width;
   logic [RG_W-1:0]   eff_groups;

   mfp_pkg::mfp_cmd_type  cmd;
   mfp_pkg::mfp_stat_type stat;

   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [7:0]        mem_wdata;
   logic [7:0]        mem_rdata;

   // register port: zero wait states, write lands on the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_bytes_ff <= 6'd32;
         row_groups_ff  <= 5'd11;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_WIDTH_BYTES: width_bytes_ff <= csr_pwdata[5:0];
            REG_ROW_GROUPS:  row_groups_ff  <= csr_pwdata[4:0];
            default:         width_bytes_ff <= width_bytes_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_WIDTH_BYTES: csr_prdata = {26'd0, width_bytes_ff};
         REG_ROW_GROUPS:  csr_prdata = {27'd0, row_groups_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // the stored values are kept as written; the datapath sees them saturated
   always_comb begin
      if (width_bytes_ff == '0) begin
         eff_width = WB_W'(1);
      end else if (32'(width_bytes_ff) > 32'(MAX_WIDTH_BYTES)) begin
         eff_width = WB_W'(MAX_WIDTH_BYTES);
      end else begin
         eff_width = WB_W'(width_bytes_ff);
      end
   end

   always_comb begin
      if (row_groups_ff == '0) begin
         eff_groups = RG_W'(1);
      end else if (32'(row_groups_ff) > 32'(MAX_ROW_GROUPS)) begin
         eff_groups = RG_W'(MAX_ROW_GROUPS);
      end else begin
         eff_groups = RG_W'(row_groups_ff);
      end
   end

   // sequencer: decides which memory operation and which response each cycle
   mfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // address math, pixel read-modify-write, row capture, reorder, cursor, output register
   mfp_datapath #(
      .MAX_WIDTH_BYTES (MAX_WIDTH_BYTES),
      .MAX_ROW_GROUPS  (MAX_ROW_GROUPS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_word   (req_word),
      .eff_width  (eff_width),
      .eff_groups (eff_groups),
      .mem_addr   (mem_addr),
      .mem_we     (mem_we),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   // frame memory, one byte per entry, row-major with the current width as stride
   mfp_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock (clock),
      .addr  (mem_addr),
      .we    (mem_we),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

`ifndef NO_ASSERTIONS
   // the clearing sweep after reset keeps the request side closed
   a_init_sweep_blocks: assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("request taken before the frame memory was cleared");

   // one item at a time: the cycle after an accept the block is busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in flight");

   // end of frame only on the closing data word of a group
   a_eof_on_last_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.end_of_frame) |->
      (rsp_word.last_of_run && rsp_word.status == mfp_pkg::STAT_DATA))
      else $error("end of frame flagged on a word that does not close a group");

   // acknowledgements are single-word responses
   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != mfp_pkg::STAT_DATA) |->
      (rsp_word.last_of_run && rsp_word.panel_byte == 8'h00))
      else $error("acknowledgement word malformed");
`endif

endmodule

`default_nettype wire

FILE: bench/mono_framebuffer_panel_reorder_tb.sv
module mono_framebuffer_panel_reorder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfp_pkg::*;

   // geometry of the block as instantiated (its default parameters)
   localparam int MAX_WIDTH_BYTES = 32;
   localparam int MAX_ROW_GROUPS  = 22;
   localparam int STORE_BYTES     = MAX_WIDTH_BYTES * MAX_ROW_GROUPS * ROWS_PER_GROUP;

   // register byte addresses on the csr port
   localparam logic [2:0] REG_WIDTH_BYTES = 3'd0;
   localparam logic [2:0] REG_ROW_GROUPS  = 3'd4;

   // a clear sweeps 8448 entries, and the long output hold-off (LONG_HOLD) adds to that;
   // several times that before we call the block hung
   localparam int STALL_LIMIT     = 40000;
   localparam int LONG_HOLD       = 300;
   localparam int SHOWN_MISMATCHES = 10;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   mfp_req_type req_word;
   logic        rsp_valid;
   logic        rsp_ready;
   mfp_rsp_type rsp_word;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // mirror of the block: pixel store, tile cursor and geometry registers
   logic [7:0]  frame_mirror [STORE_BYTES];
   int unsigned grp_cursor;
   int unsigned col_cursor;
   logic [5:0]  width_reg;
   logic [4:0]  groups_reg;

   // words the block still owes us, oldest first
   mfp_rsp_type frame_replies [$];
   mfp_rsp_type owed;

   int unsigned words_sent;
   int unsigned mismatches;

   // idling knobs for the sender and for the receiver process
   bit          send_idle;
   bit          rsp_idle;
   int unsigned hold_off_cycles;

   mono_framebuffer_panel_reorder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // geometry actually used: registers saturated into the supported range
   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_BYTES) return MAX_WIDTH_BYTES;
      return width_reg;
   endfunction

   function automatic int unsigned eff_groups();
      if (groups_reg == 0) return 1;
      if (groups_reg > MAX_ROW_GROUPS) return MAX_ROW_GROUPS;
      return groups_reg;
   endfunction

   // apply one accepted word to the mirror and queue the replies it earns
   task automatic mirror_request(input mfp_req_type w);
      int unsigned wd, gp, grp, col, addr, b, k;
      bit          frame_end;
      logic [7:0]  rows [ROWS_PER_GROUP];
      mfp_rsp_type r;
      wd = eff_width();
      gp = eff_groups();
      r = '0;
      r.last_of_run = 1'b1;
      case (w.opcode)
         OP_WRITE: begin
            if (w.pixel_x >= wd * 8 || w.pixel_y >= gp * ROWS_PER_GROUP) begin
               r.status = STAT_RANGE;
            end else begin
               // row-major, msb first within the byte
               addr = w.pixel_y * wd + (w.pixel_x >> 3);
               frame_mirror[addr][3'd7 - w.pixel_x[2:0]] = w.pixel_on;
               r.status = STAT_DONE;
            end
            frame_replies.push_back(r);
         end
         OP_CLEAR: begin
            // cursor stays where it is
            foreach (frame_mirror[i]) frame_mirror[i] = '0;
            r.status = STAT_DONE;
            frame_replies.push_back(r);
         end
         OP_EMIT: begin
            // a cursor left beyond a shrunken frame restarts at zero
            grp = (grp_cursor < gp) ? grp_cursor : 0;
            col = (col_cursor < wd) ? col_cursor : 0;
            for (int i = 0; i < ROWS_PER_GROUP; i++)
               rows[i] = frame_mirror[(grp * ROWS_PER_GROUP + i) * wd + col];
            frame_end = (col + 1 >= wd) && (grp + 1 >= gp);
            k = 0;
            // per bit pair, three bytes of four 2-bit row slices each
            for (int p = 0; p < 8; p += 2) begin
               for (int t = 0; t < 3; t++) begin
                  b = 0;
                  for (int j = 0; j < 4; j++)
                     b |= ((rows[t * 4 + j] >> (6 - p)) & 3) << (6 - 2 * j);
                  r.panel_byte   = b[7:0];
                  r.status       = STAT_DATA;
                  r.last_of_run  = (k == 11);
                  r.end_of_frame = (k == 11) && frame_end;
                  frame_replies.push_back(r);
                  k++;
               end
            end
            if (col + 1 >= wd) begin
               col_cursor = 0;
               grp_cursor = (grp + 1 >= gp) ? 0 : grp + 1;
            end else begin
               col_cursor = col + 1;
               grp_cursor = grp;
            end
         end
         default: begin
            // unused opcode just acknowledges
            r.status = STAT_DONE;
            frame_replies.push_back(r);
         end
      endcase
   endtask

   task automatic flag_mismatch(input string what, input mfp_rsp_type want,
                                input mfp_rsp_type got);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
         $display("%0t %s (byte/status/last/eof): want %02h/%0d/%0b/%0b got %02h/%0d/%0b/%0b",
                  $time, what, want.panel_byte, want.status, want.last_of_run,
                  want.end_of_frame, got.panel_byte, got.status, got.last_of_run,
                  got.end_of_frame);
   endtask

   // one word on the request channel; valid stays up between back-to-back words
   task automatic send_word(input mfp_req_type w);
      if (send_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      mirror_request(w);
      words_sent++;
   endtask

   function automatic mfp_req_type random_word(input logic [1:0] op);
      mfp_req_type w;
      w.opcode   = op;
      w.pixel_x  = 8'($urandom);
      w.pixel_y  = 9'($urandom);
      w.pixel_on = 1'($urandom);
      return w;
   endfunction

   task automatic put_pixel(input logic [7:0] x, input logic [8:0] y, input logic on);
      mfp_req_type w;
      w.opcode   = OP_WRITE;
      w.pixel_x  = x;
      w.pixel_y  = y;
      w.pixel_on = on;
      send_word(w);
   endtask

   // drop valid and hold off until every reply is in and the block takes words again
   task automatic settle_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (frame_replies.size() != 0 || !req_ready);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr)
         REG_WIDTH_BYTES: width_reg  = value[5:0];
         REG_ROW_GROUPS:  groups_reg = value[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // upper bits carry junk, the block keeps only the register width
   task automatic set_geometry(input logic [5:0] wd, input logic [4:0] gp);
      logic [31:0] junk;
      junk = $urandom;
      junk[5:0] = wd;
      csr_write(REG_WIDTH_BYTES, junk);
      junk = $urandom;
      junk[4:0] = gp;
      csr_write(REG_ROW_GROUPS, junk);
   endtask

   task automatic set_random_geometry();
      logic [5:0] wd_pick [5] = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
      logic [4:0] gp_pick [5] = '{5'd0, 5'd1, 5'd22, 5'd23, 5'd31};
      // mostly small frames so the cursor wraps often
      if ($urandom_range(0, 3) == 0)
         set_geometry(wd_pick[$urandom_range(0, 4)], gp_pick[$urandom_range(0, 4)]);
      else
         set_geometry(6'($urandom_range(1, 4)), 5'($urandom_range(1, 3)));
   endtask

   // paint a few pixels inside the tile the cursor points at, then emit it
   task automatic paint_and_emit_tile(input int unsigned max_pixels);
      int unsigned grp, col;
      grp = (grp_cursor < eff_groups()) ? grp_cursor : 0;
      col = (col_cursor < eff_width()) ? col_cursor : 0;
      repeat ($urandom_range(0, max_pixels))
         put_pixel(8'(col * 8 + $urandom_range(0, 7)),
                   9'(grp * ROWS_PER_GROUP + $urandom_range(0, ROWS_PER_GROUP - 1)),
                   1'($urandom_range(0, 3) != 0));
      send_word(random_word(OP_EMIT));
   endtask

   task automatic random_traffic(input int unsigned count, input bit allow_pause);
      int unsigned stop_at, pick;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            paint_and_emit_tile(6);
         end else if (pick < 72) begin
            put_pixel(8'($urandom_range(0, eff_width() * 8 - 1)),
                      9'($urandom_range(0, eff_groups() * ROWS_PER_GROUP - 1)),
                      1'($urandom));
         end else if (pick < 80) begin
            // anything the fields allow, mostly out of the frame
            send_word(random_word(OP_WRITE));
         end else if (pick < 88) begin
            send_word(random_word(OP_EMIT));
         end else if (pick < 94) begin
            send_word(random_word(OP_NONE));
         end else if (pick < 97) begin
            if (allow_pause) settle_replies();
         end else begin
            send_word(random_word(OP_CLEAR));
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   // pixel writes, range checks, unused opcode, emit and clear at reset geometry
   task automatic test_directed_ops();
      put_pixel(8'd0, 9'd0, 1'b1);
      put_pixel(8'd255, 9'd131, 1'b1);     // far corner of the reset frame
      put_pixel(8'd7, 9'd0, 1'b1);
      put_pixel(8'd7, 9'd0, 1'b0);         // set then clear the same bit
      put_pixel(8'd8, 9'd1, 1'b1);
      put_pixel(8'd3, 9'd11, 1'b1);
      put_pixel(8'd0, 9'd132, 1'b1);       // one row past the frame
      put_pixel(8'd255, 9'd511, 1'b1);     // every coordinate bit high
      send_word(random_word(OP_NONE));
      send_word(random_word(OP_EMIT));
      send_word(random_word(OP_EMIT));
      send_word(random_word(OP_CLEAR));
      send_word(random_word(OP_EMIT));     // clear leaves the cursor alone
   endtask

   // register values outside the supported range, and a cursor left out of bounds
   task automatic test_register_extremes();
      settle_replies();
      set_geometry(6'd0, 5'd0);            // saturates to a single tile
      put_pixel(8'd0, 9'd0, 1'b1);
      put_pixel(8'd7, 9'd11, 1'b1);
      put_pixel(8'd8, 9'd0, 1'b1);         // x beyond one byte of width
      put_pixel(8'd0, 9'd12, 1'b1);        // y beyond one group
      send_word(random_word(OP_EMIT));     // every emit ends the frame here
      send_word(random_word(OP_EMIT));
      settle_replies();
      set_geometry(6'd63, 5'd31);          // saturates to the largest frame
      put_pixel(8'd255, 9'd263, 1'b1);
      put_pixel(8'd0, 9'd264, 1'b1);
      send_word(random_word(OP_EMIT));
      settle_replies();
      set_geometry(6'd33, 5'd1);
      put_pixel(8'd255, 9'd11, 1'b1);
      send_word(random_word(OP_EMIT));
      settle_replies();
      set_geometry(6'd1, 5'd23);
      send_word(random_word(OP_EMIT));
   endtask

   // phases of mixed traffic, each with its own geometry and idling mix
   task automatic test_random_traffic();
      repeat (6) begin
         settle_replies();
         set_random_geometry();
         send_idle = ($urandom_range(0, 2) != 0);
         rsp_idle  = ($urandom_range(0, 2) != 0);
         random_traffic(45, 1'b1);
      end
   endtask

   // output held off for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      settle_replies();
      set_geometry(6'($urandom_range(1, 4)), 5'($urandom_range(1, 2)));
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      hold_off_cycles = LONG_HOLD;
      repeat (8) paint_and_emit_tile(4);
      settle_replies();
   endtask

   // closing stretch at full rate on both sides
   task automatic test_steady_tail();
      settle_replies();
      set_geometry(6'($urandom_range(1, 3)), 5'($urandom_range(1, 2)));
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      random_traffic(50, 1'b0);
   endtask

   // ---------------------------------------------------------------- processes

   // reply checker: compare each accepted word with the oldest owed reply
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_replies.size() == 0) begin
            flag_mismatch("word with no reply owed", '0, rsp_word);
         end else begin
            owed = frame_replies.pop_front();
            if (rsp_word.panel_byte !== owed.panel_byte || rsp_word.status !== owed.status ||
                rsp_word.last_of_run !== owed.last_of_run ||
                rsp_word.end_of_frame !== owed.end_of_frame)
               flag_mismatch("reply mismatch", owed, rsp_word);
         end
      end
   end

   // receiver: random stall bursts, or one long hold-off when asked
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_ready <= 1'b1;
         end else if (rsp_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: too many cycles with no word moving on any port
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet);
            $display("mono_framebuffer_panel_reorder regression: fail");
            $finish;
         end
      end
   end

   initial begin : main
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_word        = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      send_idle       = 1'b1;
      rsp_idle        = 1'b1;
      hold_off_cycles = 0;
      words_sent      = 0;
      mismatches      = 0;
      // mirror comes up in the reset state
      foreach (frame_mirror[i]) frame_mirror[i] = '0;
      grp_cursor = 0;
      col_cursor = 0;
      width_reg  = 6'd32;
      groups_reg = 5'd11;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // the block clears its store after reset; send_word waits on ready
      test_directed_ops();
      test_register_extremes();
      test_random_traffic();
      test_output_backpressure();
      test_steady_tail();

      // drain, then give stray words time to show up
      settle_replies();
      repeat (40) @(posedge clock);
      if (frame_replies.size() != 0) begin
         $display("%0d owed replies never arrived", frame_replies.size());
         mismatches += frame_replies.size();
      end

      if (mismatches == 0) begin
         $display("mono_framebuffer_panel_reorder regression: pass");
      end else begin
         $display("mono_framebuffer_panel_reorder regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mfp_pkg.sv
rtl/mfp_ram.sv
rtl/mfp_ctrl.sv
rtl/mfp_datapath.sv
rtl/mono_framebuffer_panel_reorder.sv
bench/mono_framebuffer_panel_reorder_tb.sv
